// ===== rtl/rpc_record_deframer_macros.svh =====
// Assertion macros shared by the deframer RTL files.
`ifndef RPC_RECORD_DEFRAMER_MACROS_SVH
`define RPC_RECORD_DEFRAMER_MACROS_SVH
`ifndef SYNTHESIS
`define RRD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define RRD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define RRD_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define RRD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/rrd_pkg.sv =====
// Types and codes shared by the RPC record deframer modules.
`timescale 1ns / 1ps
package rrd_pkg;

   typedef enum logic [3:0] {
      KIND_FLEN   = 4'd0,
      KIND_KEY    = 4'd1,
      KIND_TARGET = 4'd2,
      KIND_PARAM  = 4'd3,
      KIND_RESULT = 4'd4,
      KIND_PID    = 4'd5,
      KIND_MSGID  = 4'd6,
      KIND_BLEN   = 4'd7,
      KIND_BODY   = 4'd8,
      KIND_BAD    = 4'd9
   } kind_type;

   typedef enum logic [8:0] {
      PH_IDLE  = 9'b000000001,
      PH_LEN   = 9'b000000010,
      PH_TYPE  = 9'b000000100,
      PH_SLEN  = 9'b000001000,
      PH_SDATA = 9'b000010000,
      PH_PID   = 9'b000100000,
      PH_MID   = 9'b001000000,
      PH_BLEN  = 9'b010000000,
      PH_BODY  = 9'b100000000
   } phase_type;

   typedef enum logic [1:0] {
      STR_KEY    = 2'd0,
      STR_TARGET = 2'd1,
      STR_PARAM  = 2'd2,
      STR_RESULT = 2'd3
   } str_type;

   typedef struct packed {
      logic             valid;
      kind_type         kind;
      logic [63:0]      value;
      logic [31:0]      byte_index;
      logic             frame_end;
   } rrd_result_type;

endpackage

// ===== rtl/rrd_parser.sv =====
// Frame parser: phase state, counters and number assembly for one byte per cycle while item_valid is high.
`timescale 1ns / 1ps
`include "rpc_record_deframer_macros.svh"
module rrd_parser
   import rrd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           item_valid,
   input  logic [7:0]     data_byte,
   input  logic           frame_start,
   output rrd_result_type result
);

   phase_type   phase_ff, phase_in, phase_eff;
   str_type     sel_ff, sel_in;
   logic [31:0] left_ff, left_in, left_eff, left_dec;
   logic [63:0] acc_ff, acc_in, acc_eff, acc_add;
   logic [31:0] pos_ff, pos_in, pos_eff, pos_inc;
   kind_type    str_kind;

   always_comb begin
      unique case (sel_ff)
         STR_KEY:    str_kind = KIND_KEY;
         STR_TARGET: str_kind = KIND_TARGET;
         STR_PARAM:  str_kind = KIND_PARAM;
         STR_RESULT: str_kind = KIND_RESULT;
         default:    str_kind = KIND_KEY;
      endcase
   end

   always_comb begin
      // A frame start restarts the parser, and this byte is the first length byte.
      phase_eff = frame_start ? PH_LEN : phase_ff;
      acc_eff   = frame_start ? 64'd0 : acc_ff;
      pos_eff   = frame_start ? 32'd0 : pos_ff;
      left_eff  = frame_start ? 32'd0 : left_ff;
      acc_add   = acc_eff | ({56'd0, data_byte} << {pos_eff[2:0], 3'b000});
      pos_inc   = pos_eff + 32'd1;
      left_dec  = left_eff - 32'd1;

      phase_in  = phase_eff;
      acc_in    = acc_eff;
      pos_in    = pos_eff;
      left_in   = left_eff;
      sel_in    = sel_ff;
      result    = '0;
      result.kind = KIND_FLEN;

      unique case (phase_eff)
         PH_LEN: begin
            acc_in = acc_add;
            pos_in = pos_inc;
            if (pos_inc >= 32'd4) begin
               phase_in     = PH_TYPE;
               result.valid = 1'b1;
               result.kind  = KIND_FLEN;
               result.value = acc_add;
            end
         end
         PH_TYPE: begin
            if (data_byte != 8'd0) begin
               phase_in         = PH_IDLE;
               result.valid     = 1'b1;
               result.kind      = KIND_BAD;
               result.frame_end = 1'b1;
            end else begin
               phase_in = PH_SLEN;
               sel_in   = STR_KEY;
            end
         end
         PH_SLEN: begin
            left_in = {24'd0, data_byte};
            pos_in  = 32'd0;
            if (data_byte != 8'd0) begin
               phase_in = PH_SDATA;
            end else if (sel_ff == STR_RESULT) begin
               phase_in = PH_PID;
               acc_in   = 64'd0;
            end else begin
               sel_in = str_type'(sel_ff + 2'd1);
            end
         end
         PH_SDATA: begin
            result.valid      = 1'b1;
            result.kind       = str_kind;
            result.value      = {56'd0, data_byte};
            result.byte_index = pos_eff;
            pos_in            = pos_inc;
            left_in           = left_dec;
            if (left_dec == 32'd0) begin
               if (sel_ff == STR_RESULT) begin
                  phase_in = PH_PID;
                  acc_in   = 64'd0;
                  pos_in   = 32'd0;
               end else begin
                  phase_in = PH_SLEN;
                  sel_in   = str_type'(sel_ff + 2'd1);
               end
            end
         end
         PH_PID: begin
            acc_in = acc_add;
            pos_in = pos_inc;
            if (pos_inc >= 32'd8) begin
               phase_in     = PH_MID;
               acc_in       = 64'd0;
               pos_in       = 32'd0;
               result.valid = 1'b1;
               result.kind  = KIND_PID;
               result.value = acc_add;
            end
         end
         PH_MID: begin
            acc_in = acc_add;
            pos_in = pos_inc;
            if (pos_inc >= 32'd4) begin
               phase_in     = PH_BLEN;
               acc_in       = 64'd0;
               pos_in       = 32'd0;
               result.valid = 1'b1;
               result.kind  = KIND_MSGID;
               result.value = acc_add;
            end
         end
         PH_BLEN: begin
            acc_in = acc_add;
            pos_in = pos_inc;
            if (pos_inc >= 32'd4) begin
               left_in          = acc_add[31:0];
               pos_in           = 32'd0;
               phase_in         = (acc_add[31:0] == 32'd0) ? PH_IDLE : PH_BODY;
               result.valid     = 1'b1;
               result.kind      = KIND_BLEN;
               result.value     = acc_add;
               result.frame_end = (acc_add[31:0] == 32'd0);
            end
         end
         PH_BODY: begin
            result.valid      = 1'b1;
            result.kind       = KIND_BODY;
            result.value      = {56'd0, data_byte};
            result.byte_index = pos_eff;
            pos_in            = pos_inc;
            left_in           = left_dec;
            if (left_dec == 32'd0) begin
               phase_in         = PH_IDLE;
               result.frame_end = 1'b1;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         sel_ff   <= STR_KEY;
         left_ff  <= 32'd0;
         acc_ff   <= 64'd0;
         pos_ff   <= 32'd0;
      end else if (item_valid) begin
         phase_ff <= phase_in;
         sel_ff   <= sel_in;
         left_ff  <= left_in;
         acc_ff   <= acc_in;
         pos_ff   <= pos_in;
      end
   end

   `RRD_ASSERT_NEXT(a_end_goes_idle, clock, reset, item_valid && result.valid && result.frame_end, phase_ff == PH_IDLE, "frame end did not return the parser to idle")

endmodule

// ===== rtl/rrd_skid.sv =====
// Result register with a skid slot so results can wait while bytes keep coming.
`timescale 1ns / 1ps
`include "rpc_record_deframer_macros.svh"
module rrd_skid
   import rrd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  rrd_result_type push_data,
   output logic           full,
   output logic           out_valid,
   output rrd_result_type out_data,
   input  logic           out_stall
);

   logic           main_v_ff, main_v_in;
   logic           skid_v_ff, skid_v_in;
   rrd_result_type main_ff, main_in;
   rrd_result_type skid_ff, skid_in;
   logic           main_take;

   assign main_take = main_v_ff && !out_stall;

   always_comb begin
      main_v_in = main_v_ff;
      skid_v_in = skid_v_ff;
      main_in   = main_ff;
      skid_in   = skid_ff;
      priority if (skid_v_ff) begin
         if (main_take) begin
            main_in   = skid_ff;
            skid_v_in = 1'b0;
         end
      end else if (push) begin
         if (!main_v_ff || main_take) begin
            main_in   = push_data;
            main_v_in = 1'b1;
         end else begin
            skid_in   = push_data;
            skid_v_in = 1'b1;
         end
      end else if (main_take) begin
         main_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         main_v_ff <= main_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_v_ff;
   assign out_valid = main_v_ff;
   assign out_data  = main_ff;

   `RRD_ASSERT_NOW(a_skid_needs_main, clock, reset, skid_v_ff, main_v_ff, "skid slot holds a result while the output register is empty")
   `RRD_ASSERT_NOW(a_no_push_when_full, clock, reset, skid_v_ff, !push, "result pushed while both slots are full")
   `RRD_ASSERT_NEXT(a_stall_fills_skid, clock, reset, push && main_v_ff && out_stall, skid_v_ff, "stalled result was not parked in the skid slot")
   `RRD_ASSERT_NEXT(a_skid_drains, clock, reset, skid_v_ff && !out_stall, !skid_v_ff, "skid slot did not drain when the output was taken")

endmodule

// ===== rtl/rpc_record_deframer.sv =====
// An accepted byte is held in the input register, parsed, and its result registered for rsp_.
// Throughput: one byte per cycle while req_stall is low; the parser updates its state in a single pass.
// The result register and its skid slot let bytes keep arriving while a result waits.
// req_stall rises only when the input register and both result slots are occupied.
// Reset (synchronous): the parser returns to idle and all pipeline slots are emptied.
`timescale 1ns / 1ps
module rpc_record_deframer
   import rrd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_frame_start,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_kind,
   output logic [63:0] rsp_value,
   output logic [31:0] rsp_byte_index,
   output logic        rsp_frame_end
);

   logic           in_v_ff, in_v_in;
   logic [7:0]     in_byte_ff;
   logic           in_start_ff;
   logic           advance;
   logic           out_full;
   rrd_result_type result;
   rrd_result_type out_data;

   assign advance   = in_v_ff && !out_full;
   assign req_stall = in_v_ff && out_full;

   always_comb begin
      in_v_in = in_v_ff;
      if (req_valid && !req_stall) begin
         in_v_in = 1'b1;
      end else if (advance) begin
         in_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else begin
         in_v_ff <= in_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff  <= req_data_byte;
         in_start_ff <= req_frame_start;
      end
   end

   rrd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (advance),
      .data_byte   (in_byte_ff),
      .frame_start (in_start_ff),
      .result      (result)
   );

   rrd_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (advance && result.valid),
      .push_data (result),
      .full      (out_full),
      .out_valid (rsp_valid),
      .out_data  (out_data),
      .out_stall (rsp_stall)
   );

   assign rsp_kind       = out_data.kind;
   assign rsp_value      = out_data.value;
   assign rsp_byte_index = out_data.byte_index;
   assign rsp_frame_end  = out_data.frame_end;

endmodule

// ===== dv/rpc_record_deframer_tb.sv =====
// Self-checking testbench for the RPC record deframer: framed byte streams in, tagged fields out.
`timescale 1ns / 1ps
module rpc_record_deframer_tb;
   import rrd_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 500000;
   localparam int unsigned RANDOM_ITEMS = 1200;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_frame_start = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_kind;
   logic [63:0] rsp_value;
   logic [31:0] rsp_byte_index;
   logic        rsp_frame_end;

   // Shadow parser state.
   phase_type   parse_phase = PH_IDLE;
   str_type     string_sel = STR_KEY;
   logic [31:0] content_left = '0;
   logic [63:0] number_value = '0;
   logic [31:0] field_pos = '0;

   rrd_result_type expected_fields[$];
   logic [7:0]     frame_bytes[$];

   bit          idle_enable = 1'b0;
   int unsigned stall_left = 0;
   int unsigned cycle_count = 0;
   int unsigned parsed_count = 0;
   int unsigned error_count = 0;

   rpc_record_deframer dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_value       (rsp_value),
      .rsp_byte_index  (rsp_byte_index),
      .rsp_frame_end   (rsp_frame_end)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Result-side backpressure in bursts of random length, started only while idle_enable is set.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (idle_enable && $urandom_range(0, 3) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : check_results
      rrd_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_fields.size() == 0) begin
            error_count <= error_count + 1;
            if (error_count < 10)
               $display("Unexpected result: kind %0d value %h index %0d end %0b",
                        rsp_kind, rsp_value, rsp_byte_index, rsp_frame_end);
         end else begin
            want = expected_fields.pop_front();
            if (rsp_kind !== want.kind || rsp_value !== want.value ||
                rsp_byte_index !== want.byte_index || rsp_frame_end !== want.frame_end) begin
               error_count <= error_count + 1;
               if (error_count < 10)
                  $display("Mismatch: expected kind %0d value %h index %0d end %0b, %s",
                           want.kind, want.value, want.byte_index, want.frame_end,
                           $sformatf("got kind %0d value %h index %0d end %0b",
                                     rsp_kind, rsp_value, rsp_byte_index, rsp_frame_end));
            end
         end
      end
   end

   // Numbers arrive little-endian; returns 1 once the last byte is in.
   function automatic bit add_number_byte(input logic [7:0] data, input int unsigned nbytes);
      number_value = number_value | ({56'd0, data} << (8 * field_pos[2:0]));
      field_pos = field_pos + 1;
      return field_pos >= nbytes;
   endfunction

   function automatic void start_number(input phase_type next_phase);
      parse_phase = next_phase;
      number_value = '0;
      field_pos = '0;
   endfunction

   // After the result string the process id follows.
   function automatic void next_string();
      if (string_sel == STR_RESULT) begin
         start_number(PH_PID);
      end else begin
         string_sel = str_type'(string_sel + 2'd1);
         parse_phase = PH_SLEN;
      end
   endfunction

   // Advances the shadow parser by one byte; returns 0 if the byte was ignored.
   function automatic bit parse_byte(input logic [7:0] data, input logic start);
      rrd_result_type r;
      bit emit;
      bit parsed;
      r = '0;
      r.valid = 1'b1;
      emit = 1'b0;
      parsed = 1'b1;
      if (start) begin
         content_left = '0;
         start_number(PH_LEN);
      end
      case (parse_phase)
         PH_LEN: begin
            if (add_number_byte(data, 4)) begin
               parse_phase = PH_TYPE;
               r.kind = KIND_FLEN;
               r.value = number_value;
               emit = 1'b1;
            end
         end
         PH_TYPE: begin
            if (data != 8'h00) begin
               parse_phase = PH_IDLE;
               r.kind = KIND_BAD;
               r.frame_end = 1'b1;
               emit = 1'b1;
            end else begin
               string_sel = STR_KEY;
               parse_phase = PH_SLEN;
            end
         end
         PH_SLEN: begin
            content_left = {24'd0, data};
            field_pos = '0;
            if (data == 8'h00) next_string();
            else parse_phase = PH_SDATA;
         end
         PH_SDATA: begin
            r.kind = kind_type'(KIND_KEY + string_sel);
            r.value = {56'd0, data};
            r.byte_index = field_pos;
            field_pos = field_pos + 1;
            content_left = content_left - 1;
            if (content_left == 0) next_string();
            emit = 1'b1;
         end
         PH_PID: begin
            if (add_number_byte(data, 8)) begin
               r.kind = KIND_PID;
               r.value = number_value;
               start_number(PH_MID);
               emit = 1'b1;
            end
         end
         PH_MID: begin
            if (add_number_byte(data, 4)) begin
               r.kind = KIND_MSGID;
               r.value = number_value;
               start_number(PH_BLEN);
               emit = 1'b1;
            end
         end
         PH_BLEN: begin
            if (add_number_byte(data, 4)) begin
               r.kind = KIND_BLEN;
               r.value = number_value;
               content_left = number_value[31:0];
               field_pos = '0;
               r.frame_end = (content_left == 0);
               parse_phase = (content_left == 0) ? PH_IDLE : PH_BODY;
               emit = 1'b1;
            end
         end
         PH_BODY: begin
            r.kind = KIND_BODY;
            r.value = {56'd0, data};
            r.byte_index = field_pos;
            field_pos = field_pos + 1;
            content_left = content_left - 1;
            if (content_left == 0) begin
               parse_phase = PH_IDLE;
               r.frame_end = 1'b1;
            end
            emit = 1'b1;
         end
         default: begin
            parse_phase = PH_IDLE;
            parsed = 1'b0;
         end
      endcase
      if (emit) expected_fields.push_back(r);
      return parsed;
   endfunction

   task automatic send_item(input logic [7:0] data, input logic start);
      int unsigned gap;
      gap = (idle_enable && $urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= data;
      req_frame_start <= start;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (parse_byte(data, start)) parsed_count++;
   endtask

   function automatic void push_number(input logic [63:0] value, input int unsigned nbytes);
      for (int i = 0; i < nbytes; i++) frame_bytes.push_back(value[8 * i +: 8]);
   endfunction

   function automatic void push_string(input int unsigned len);
      frame_bytes.push_back(len[7:0]);
      for (int i = 0; i < len; i++) frame_bytes.push_back(8'($urandom));
   endfunction

   function automatic void build_frame(input logic [31:0] flen, input logic [7:0] msg_type,
                                       input int unsigned key_len, input int unsigned target_len,
                                       input int unsigned param_len, input int unsigned result_len,
                                       input logic [63:0] pid, input logic [31:0] msg_id,
                                       input logic [31:0] body_len, input int unsigned body_sent);
      push_number({32'd0, flen}, 4);
      frame_bytes.push_back(msg_type);
      push_string(key_len);
      push_string(target_len);
      push_string(param_len);
      push_string(result_len);
      push_number(pid, 8);
      push_number({32'd0, msg_id}, 4);
      push_number({32'd0, body_len}, 4);
      for (int i = 0; i < body_sent; i++) frame_bytes.push_back(8'($urandom));
   endfunction

   // Sends the first count bytes of the built frame, the first one flagged as frame start.
   task automatic send_frame(input int unsigned count);
      int unsigned n;
      n = (count < frame_bytes.size()) ? count : frame_bytes.size();
      for (int i = 0; i < n; i++) send_item(frame_bytes[i], i == 0);
      frame_bytes.delete();
   endtask

   task automatic send_random_frame();
      logic [7:0]  msg_type;
      logic [31:0] body_len;
      int unsigned lens[4];
      int unsigned body_sent;
      int unsigned count;
      msg_type = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
      foreach (lens[i])
         lens[i] = ($urandom_range(0, 24) == 0) ? $urandom_range(5, 255) : $urandom_range(0, 4);
      if ($urandom_range(0, 9) == 0) begin
         // Huge body length; the frame is cut short by the next frame start.
         body_len = $urandom;
         body_sent = $urandom_range(0, 6);
      end else begin
         body_len = $urandom_range(0, 6);
         body_sent = body_len;
      end
      build_frame($urandom, msg_type, lens[0], lens[1], lens[2], lens[3],
                  {$urandom, $urandom}, $urandom, body_len, body_sent);
      count = ($urandom_range(0, 9) == 0) ? $urandom_range(1, frame_bytes.size())
                                          : frame_bytes.size();
      send_frame(count);
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 4)) send_item(8'($urandom), $urandom_range(0, 3) == 0);
      end
   endtask

   task automatic test_idle_bytes();
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
   endtask

   task automatic test_bad_type();
      build_frame(32'hFFFF_FFFF, 8'hFF, 0, 0, 0, 0, '0, '0, '0, 0);
      send_frame(5);
      build_frame(32'h0000_0000, 8'h01, 0, 0, 0, 0, '0, '0, '0, 0);
      send_frame(6);
   endtask

   task automatic test_empty_frame();
      build_frame(32'h0000_0000, 8'h00, 0, 0, 0, 0, '0, '0, '0, 0);
      send_frame(frame_bytes.size());
   endtask

   task automatic test_full_frame();
      build_frame(32'hFFFF_FFFF, 8'h00, 1, 2, 1, 2, 64'hFFFF_FFFF_FFFF_FFFF,
                  32'hFFFF_FFFF, 32'd2, 2);
      send_frame(frame_bytes.size());
   endtask

   task automatic test_resync();
      // A new frame start lands in the middle of the body.
      build_frame(32'h0000_0020, 8'h00, 0, 0, 0, 0, 64'h0123_4567_89AB_CDEF,
                  32'h8000_0001, 32'd5, 2);
      send_frame(frame_bytes.size());
      test_empty_frame();
   endtask

   task automatic test_random_frames();
      while (parsed_count < RANDOM_ITEMS) begin
         idle_enable = ($urandom_range(0, 3) != 0);
         send_random_frame();
      end
   endtask

   task automatic test_back_to_back();
      idle_enable = 1'b0;
      repeat (8) send_random_frame();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_idle_bytes();
      test_bad_type();
      test_empty_frame();
      test_full_frame();
      test_resync();
      test_random_frames();
      test_back_to_back();
      req_valid <= 1'b0;
      while (expected_fields.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
